// ===== src/dip_pkg.sv =====
package dip_pkg;

   // character codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;

   // value of a question-mark token
   localparam logic signed [31:0] MISSING_VALUE = -32'sd1;
   // largest magnitude a negative number may reach
   localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

   // result queue sizing
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;
   // fill level up to which a new byte is taken (two free entries)
   localparam logic [Q_CNT_W-1:0] Q_ACCEPT_MAX = Q_CNT_W'(Q_DEPTH - 2);

   // parser modes
   typedef enum logic [2:0] {
      MODE_SKIP = 3'b001,
      MODE_QRUN = 3'b010,
      MODE_NUM  = 3'b100
   } mode_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] number;
      logic               missing;
      logic               overflow;
      logic               run_last;
   } rsp_payload_type;

endpackage

// ===== src/decimal_integer_stream_parse_core.sv =====
// A result is registered into the result queue when the byte that causes it is transferred.
// Throughput: one byte per cycle while req_stall is low; the per-byte times-ten update is combinational.
// A byte that yields two results pushes both into the result queue together; req_stall rises while the
// four-entry result queue has fewer than two free entries.
// Reset (synchronous, active high) returns the parser to skipping with no token open
// and empties the result queue.
module decimal_integer_stream_parse_core import dip_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   // parser state
   mode_type    mode_ff, mode_in;
   logic [31:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        ovf_ff, ovf_in;

   // result queue
   rsp_payload_type        q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]     count_ff, count_in;

   logic            req_xfer;
   logic            rsp_xfer;
   logic            is_digit;
   logic            is_minus;
   logic            is_qmark;
   logic [35:0]     wide;
   logic            open_tok;
   logic            head_v;
   logic            tail_v;
   rsp_payload_type head_res;
   rsp_payload_type tail_res;
   rsp_payload_type first_res;
   rsp_payload_type second_res;
   logic [1:0]      push_cnt;

   // result of a closed number token
   function automatic rsp_payload_type num_result(input logic [31:0] acc,
                                                  input logic neg, input logic ovf);
      rsp_payload_type r;
      r.number   = neg ? (32'sd0 - $signed(acc)) : $signed(acc);
      r.missing  = 1'b0;
      r.overflow = ovf | (!neg && (acc == MAG_LIMIT));
      r.run_last = 1'b0;
      return r;
   endfunction

   function automatic rsp_payload_type miss_result();
      rsp_payload_type r;
      r.number   = MISSING_VALUE;
      r.missing  = 1'b1;
      r.overflow = 1'b0;
      r.run_last = 1'b0;
      return r;
   endfunction

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   assign is_digit = (req_payload.text_byte >= CHAR_ZERO) && (req_payload.text_byte <= CHAR_NINE);
   assign is_minus = (req_payload.text_byte == CHAR_MINUS);
   assign is_qmark = (req_payload.text_byte == CHAR_QMARK);

   // acc * 10 + digit, as two shifts and adds
   assign wide = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
               + {32'd0, req_payload.text_byte[3:0]};

   // per-byte parse step
   always_comb begin
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      open_tok = 1'b0;
      head_v   = 1'b0;
      tail_v   = 1'b0;
      head_res = miss_result();
      tail_res = miss_result();
      if (req_xfer) begin
         case (mode_ff)
            MODE_QRUN: begin
               // byte after the run is swallowed
               if (!is_qmark) begin
                  head_v  = 1'b1;
                  mode_in = MODE_SKIP;
               end
            end
            MODE_NUM: begin
               if (is_digit) begin
                  acc_in = wide[31:0];
                  if (wide > {4'd0, MAG_LIMIT}) begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  head_v   = 1'b1;
                  head_res = num_result(acc_ff, neg_ff, ovf_ff);
                  open_tok = 1'b1;
               end
            end
            default: begin
               open_tok = 1'b1;
            end
         endcase

         // terminating byte may open the next token
         if (open_tok) begin
            if (is_digit) begin
               mode_in = MODE_NUM;
               acc_in  = {28'd0, req_payload.text_byte[3:0]};
               neg_in  = 1'b0;
               ovf_in  = 1'b0;
            end else if (is_minus) begin
               mode_in = MODE_NUM;
               acc_in  = 32'd0;
               neg_in  = 1'b1;
               ovf_in  = 1'b0;
            end else if (is_qmark) begin
               mode_in = MODE_QRUN;
            end else begin
               mode_in = MODE_SKIP;
            end
         end

         // end of text flushes the open token
         if (req_payload.end_of_text) begin
            if (mode_in == MODE_QRUN) begin
               tail_v = 1'b1;
            end else if (mode_in == MODE_NUM) begin
               tail_v   = 1'b1;
               tail_res = num_result(acc_in, neg_in, ovf_in);
            end
            mode_in = MODE_SKIP;
            acc_in  = 32'd0;
            neg_in  = 1'b0;
            ovf_in  = 1'b0;
         end
      end
   end

   // order results and mark the last one of the byte
   always_comb begin
      first_res  = head_v ? head_res : tail_res;
      second_res = tail_res;
      first_res.run_last  = !(head_v && tail_v);
      second_res.run_last = 1'b1;
      push_cnt = {1'b0, head_v} + {1'b0, tail_v};
   end

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + Q_PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + Q_PTR_W'(rsp_xfer);
      count_in  = count_ff + Q_CNT_W'(push_cnt) - Q_CNT_W'(rsp_xfer);
   end

   assign req_stall   = (count_ff > Q_ACCEPT_MAX);
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = q_ff[rd_ptr_ff];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_SKIP;
         acc_ff    <= 32'd0;
         neg_ff    <= 1'b0;
         ovf_ff    <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         neg_ff    <= neg_in;
         ovf_ff    <= ovf_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         q_ff[wr_ptr_ff] <= first_res;
      end
      if (push_cnt == 2'd2) begin
         q_ff[wr_ptr_ff + Q_PTR_W'(1)] <= second_res;
      end
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("result queue overfilled");

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_payload.end_of_text) |=> (mode_ff == MODE_SKIP && acc_ff == 32'd0))
      else $error("end of text did not clear parser state");

   a_missing_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.missing) |-> (rsp_payload.number == MISSING_VALUE
                                              && !rsp_payload.overflow))
      else $error("missing result with wrong value");

   a_two_results_room: assert property (@(posedge clock) disable iff (reset)
      (push_cnt == 2'd2) |-> (count_ff <= Q_ACCEPT_MAX))
      else $error("two results pushed without room");

endmodule

// ===== tb/number_stream_checker.sv =====
module number_stream_checker import dip_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_payload,
   output int              mismatches,
   output int              numbers_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // predicted parser state
   mode_type        mode;
   logic [31:0]     magnitude;
   logic            is_negative;
   logic            wrapped;

   // numbers still owed by the block, oldest first
   rsp_payload_type expected_numbers[$];
   rsp_payload_type want;

   function automatic logic is_digit(logic [7:0] ch);
      return ch >= CHAR_ZERO && ch <= CHAR_NINE;
   endfunction

   function automatic rsp_payload_type close_number();
      rsp_payload_type r;
      r.number   = is_negative ? -magnitude : magnitude;
      r.missing  = 1'b0;
      // +2^31 does not fit, -2^31 does
      r.overflow = wrapped | (!is_negative && magnitude == MAG_LIMIT);
      r.run_last = 1'b0;
      return r;
   endfunction

   function automatic rsp_payload_type missing_token();
      rsp_payload_type r;
      r.number   = MISSING_VALUE;
      r.missing  = 1'b1;
      r.overflow = 1'b0;
      r.run_last = 1'b0;
      return r;
   endfunction

   task automatic clear_parser();
      mode        = MODE_SKIP;
      magnitude   = '0;
      is_negative = 1'b0;
      wrapped     = 1'b0;
   endtask

   // a byte seen outside any token may open one
   task automatic start_token(logic [7:0] ch);
      if (is_digit(ch)) begin
         mode        = MODE_NUM;
         magnitude   = 32'(ch) - 32'(CHAR_ZERO);
         is_negative = 1'b0;
         wrapped     = 1'b0;
      end else if (ch == CHAR_MINUS) begin
         mode        = MODE_NUM;
         magnitude   = '0;
         is_negative = 1'b1;
         wrapped     = 1'b0;
      end else if (ch == CHAR_QMARK) begin
         mode = MODE_QRUN;
      end else begin
         mode = MODE_SKIP;
      end
   endtask

   // advance the parser by one text byte and queue the numbers it yields
   task automatic parse_text_byte(req_payload_type item);
      rsp_payload_type produced[$];
      logic [35:0]     wide;
      logic [7:0]      ch;
      ch = item.text_byte;
      case (mode)
         MODE_QRUN: begin
            // the byte ending a '?' run is swallowed
            if (ch != CHAR_QMARK) begin
               produced.insert(produced.size(), missing_token());
               mode = MODE_SKIP;
            end
         end
         MODE_NUM: begin
            if (is_digit(ch)) begin
               wide = 36'(magnitude) * 36'd10 + 36'(ch - CHAR_ZERO);
               if (wide > 36'(MAG_LIMIT)) wrapped = 1'b1;
               magnitude = wide[31:0];
            end else begin
               produced.insert(produced.size(), close_number());
               start_token(ch);
            end
         end
         default: start_token(ch);
      endcase
      // end of text flushes whatever token is open
      if (item.end_of_text) begin
         if (mode == MODE_QRUN) produced.insert(produced.size(), missing_token());
         else if (mode == MODE_NUM) produced.insert(produced.size(), close_number());
         clear_parser();
      end
      if (produced.size() > 0) produced[produced.size() - 1].run_last = 1'b1;
      expected_numbers = {expected_numbers, produced};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         expected_numbers.delete();
         mismatches = 0;
      end else begin
         if (req_valid && !req_stall) parse_text_byte(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (expected_numbers.size() == 0) begin
               $error("unexpected result transfer: number %0d", rsp_payload.number);
               mismatches += 1;
            end else begin
               want = expected_numbers.pop_front();
               if (rsp_payload.number !== want.number) begin
                  $error("number: expected %0d, got %0d", want.number, rsp_payload.number);
                  mismatches += 1;
               end
               if (rsp_payload.missing !== want.missing) begin
                  $error("missing: expected %0b, got %0b", want.missing,
                         rsp_payload.missing);
                  mismatches += 1;
               end
               if (rsp_payload.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow,
                         rsp_payload.overflow);
                  mismatches += 1;
               end
               if (rsp_payload.run_last !== want.run_last) begin
                  $error("run_last: expected %0b, got %0b", want.run_last,
                         rsp_payload.run_last);
                  mismatches += 1;
               end
            end
         end
      end
      numbers_pending <= expected_numbers.size();
   end

endmodule

// ===== tb/tb.sv =====
module tb;
   import dip_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET  = 850;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_CYCLES  = 64;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   int  mismatches;
   int  numbers_pending;
   int  cycle_count = 0;
   int  items_sent = 0;
   bit  steady = 1'b0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;

   // magnitudes at the edge of the signed 32-bit range
   string limit_texts[6] = '{"2147483647", "2147483648", "-2147483648",
                             "-2147483649", "4294967295", "4294967296"};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   decimal_integer_stream_parse_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   number_stream_checker number_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .mismatches      (mismatches),
      .numbers_pending (numbers_pending)
   );

   // runaway guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left -= 1;
         end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 16);
         end
      end
   end

   // one byte transfer; called and returns at a falling edge
   task automatic send_byte(logic [7:0] ch, logic eot);
      // idle cycles, each taken at random
      while (!steady && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{text_byte: ch, end_of_text: eot};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent += 1;
   endtask

   task automatic send_text(string s, logic eot_last);
      foreach (s[i]) send_byte(s[i], eot_last && i == s.len() - 1);
   endtask

   // one random token: mostly well-formed, some noise
   task automatic send_token();
      logic [7:0] chars[$];
      int         kind;
      int         count;
      string      s;
      kind = $urandom_range(99);
      if (kind < 40) begin
         if ($urandom_range(2) == 0) chars.insert(chars.size(), CHAR_MINUS);
         count = ($urandom_range(9) < 8) ? $urandom_range(1, 4) : $urandom_range(9, 12);
         repeat (count) chars.insert(chars.size(), CHAR_ZERO + 8'($urandom_range(9)));
      end else if (kind < 50) begin
         s = limit_texts[$urandom_range(5)];
         foreach (s[i]) chars.insert(chars.size(), s[i]);
      end else if (kind < 65) begin
         count = $urandom_range(1, 3);
         repeat (count) chars.insert(chars.size(), CHAR_QMARK);
         chars.insert(chars.size(), 8'($urandom_range(255)));
      end else if (kind < 80) begin
         count = $urandom_range(1, 2);
         repeat (count) begin
            case ($urandom_range(3))
               0: chars.insert(chars.size(), " ");
               1: chars.insert(chars.size(), ",");
               2: chars.insert(chars.size(), 8'h0A);
               default: chars.insert(chars.size(), 8'($urandom_range(255)));
            endcase
         end
      end else begin
         count = $urandom_range(1, 4);
         repeat (count) chars.insert(chars.size(), 8'($urandom_range(255)));
      end
      foreach (chars[i])
         send_byte(chars[i], ($urandom_range(99) < 4) ||
                   (i == chars.size() - 1 && $urandom_range(9) == 0));
   endtask

   // stimulus
   initial begin
      bit hold_done;
      bit pause_done;
      hold_done   = 1'b0;
      pause_done  = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: lone minus at end of text, '?' runs, two results from one
      // byte, byte extremes, overflow, non-digit terminator
      send_text("-", 1'b1);
      send_text("??5", 1'b0);
      send_text("?", 1'b1);
      send_text("7-", 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("3000000000", 1'b1);
      send_text("1a", 1'b1);
      send_text("?-", 1'b0);

      // random token stream
      while (items_sent < ITEM_TARGET) begin
         steady = (items_sent >= 600 && items_sent < 720);
         if (!hold_done && items_sent >= 300) begin
            hold_done    = 1'b1;
            hold_request = 1'b1;
         end
         if (!pause_done && items_sent >= 500) begin
            // sender pause until the block has drained
            pause_done = 1'b1;
            req_valid <= 1'b0;
            do @(negedge clock); while (numbers_pending != 0);
         end
         send_token();
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      while (numbers_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && numbers_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
